/* rtl/core/midpoint_ellipse_rasterizer_assert.svh */
// Assertion macros for the midpoint ellipse rasterizer checker.
// Users need clk and rst_n in scope.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_ASSERT_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MER_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MER_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/mer_pkg.sv */
// Shared types and constants for the midpoint ellipse rasterizer.
// Used by the sequencer, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package mer_pkg;

    localparam int COORD_BITS_DEF  = 12;
    localparam int RADIUS_BITS_DEF = 11;

    // Input word action codes
    localparam logic ACT_START   = 1'b0;
    localparam logic ACT_ADVANCE = 1'b1;

    // Datapath operations issued by the sequencer
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQ_RX,
        OP_SQ_RY,
        OP_RX2_RY,
        OP_INIT,
        OP_TX_SQ,
        OP_RY2_TX,
        OP_TY_SQ,
        OP_RX2_TY,
        OP_RX2_RY2,
        OP_SWITCH,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        logic active;
        logic need_switch;
        logic out_free;
    } dp_status_t;

endpackage

/* rtl/core/mer_ctrl.sv */
// Sequencer for the midpoint ellipse rasterizer.
// Steps the shared multiplier through setup and region switch and paces the emit step; depends on mer_pkg.
`timescale 1ns / 1ps

module mer_ctrl
    import mer_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       action,
    output logic       in_stall,
    output dp_op_t     op,
    input  dp_status_t status
);

    typedef enum logic [11:0] {
        ST_IDLE     = 12'b0000_0000_0001,
        ST_SQ_RX    = 12'b0000_0000_0010,
        ST_SQ_RY    = 12'b0000_0000_0100,
        ST_RX2_RY   = 12'b0000_0000_1000,
        ST_INIT     = 12'b0000_0001_0000,
        ST_TX_SQ    = 12'b0000_0010_0000,
        ST_RY2_TX   = 12'b0000_0100_0000,
        ST_TY_SQ    = 12'b0000_1000_0000,
        ST_RX2_TY   = 12'b0001_0000_0000,
        ST_RX2_RY2  = 12'b0010_0000_0000,
        ST_SWITCH   = 12'b0100_0000_0000,
        ST_EMIT     = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (action == ACT_START)
                    begin
                        op         = OP_LOAD;
                        state_next = ST_SQ_RX;
                    end
                    else if (status.active)
                    begin
                        // rebuild the decision term before the first region-two word
                        state_next = status.need_switch ? ST_TX_SQ : ST_EMIT;
                    end
                end
            end
            ST_SQ_RX:
            begin
                op         = OP_SQ_RX;
                state_next = ST_SQ_RY;
            end
            ST_SQ_RY:
            begin
                op         = OP_SQ_RY;
                state_next = ST_RX2_RY;
            end
            ST_RX2_RY:
            begin
                op         = OP_RX2_RY;
                state_next = ST_INIT;
            end
            ST_INIT:
            begin
                op         = OP_INIT;
                state_next = ST_IDLE;
            end
            ST_TX_SQ:
            begin
                op         = OP_TX_SQ;
                state_next = ST_RY2_TX;
            end
            ST_RY2_TX:
            begin
                op         = OP_RY2_TX;
                state_next = ST_TY_SQ;
            end
            ST_TY_SQ:
            begin
                op         = OP_TY_SQ;
                state_next = ST_RX2_TY;
            end
            ST_RX2_TY:
            begin
                op         = OP_RX2_TY;
                state_next = ST_RX2_RY2;
            end
            ST_RX2_RY2:
            begin
                op         = OP_RX2_RY2;
                state_next = ST_SWITCH;
            end
            ST_SWITCH:
            begin
                op         = OP_SWITCH;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // hold until the output register can take the word
                if (status.out_free)
                begin
                    op         = OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/mer_dp.sv */
// Datapath for the midpoint ellipse rasterizer: ellipse state, shared multiplier,
// step arithmetic and the output register. Depends on mer_pkg.
`timescale 1ns / 1ps

module mer_dp
    import mer_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int RADIUS_BITS = RADIUS_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  dp_op_t                        op,
    output dp_status_t                    status,
    input  logic [COORD_BITS-1:0]         center_x,
    input  logic [COORD_BITS-1:0]         center_y,
    input  logic [RADIUS_BITS-1:0]        axis_x,
    input  logic [RADIUS_BITS-1:0]        axis_y,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [COORD_BITS+1:0]  pt0_x,
    output logic signed [COORD_BITS+1:0]  pt0_y,
    output logic signed [COORD_BITS+1:0]  pt1_x,
    output logic signed [COORD_BITS+1:0]  pt1_y,
    output logic signed [COORD_BITS+1:0]  pt2_x,
    output logic signed [COORD_BITS+1:0]  pt2_y,
    output logic signed [COORD_BITS+1:0]  pt3_x,
    output logic signed [COORD_BITS+1:0]  pt3_y,
    output logic                          last
);

    localparam int R       = RADIUS_BITS;
    localparam int SQ_W    = 2 * R;
    localparam int OFF_W   = R + 1;
    localparam int SLOPE_W = 3 * R + 3;
    localparam int DEC_W   = 4 * R + 4;
    localparam int MB_W    = 2 * R + 4;
    localparam int PT_W    = COORD_BITS + 2;
    localparam int SUM_W   = (PT_W > OFF_W + 1) ? PT_W : OFF_W + 1;

    // control state
    logic active_reg;
    logic region2_reg;
    logic out_valid_reg;

    // ellipse state
    logic        [COORD_BITS-1:0] mid_x_reg;
    logic        [COORD_BITS-1:0] mid_y_reg;
    logic        [R-1:0]          rad_x_reg;
    logic        [SQ_W-1:0]       rx2_reg;
    logic        [SQ_W-1:0]       ry2_reg;
    logic        [OFF_W-1:0]      off_x_reg;
    logic        [OFF_W-1:0]      off_y_reg;
    logic signed [SLOPE_W-1:0]    sdx_reg;
    logic signed [SLOPE_W-1:0]    sdy_reg;
    logic signed [DEC_W-1:0]      dec_reg;
    logic        [DEC_W-1:0]      prod_reg;
    logic signed [DEC_W-1:0]      acc_reg;

    // output word
    logic signed [PT_W-1:0] pt0_x_reg;
    logic signed [PT_W-1:0] pt0_y_reg;
    logic signed [PT_W-1:0] pt1_x_reg;
    logic signed [PT_W-1:0] pt1_y_reg;
    logic signed [PT_W-1:0] pt2_x_reg;
    logic signed [PT_W-1:0] pt2_y_reg;
    logic signed [PT_W-1:0] pt3_x_reg;
    logic signed [PT_W-1:0] pt3_y_reg;
    logic                   last_reg;

    // multiplier
    logic [SQ_W-1:0]  mul_a;
    logic [MB_W-1:0]  mul_b;
    logic [DEC_W-1:0] mul_p;
    logic [R+1:0]     tx;
    logic [OFF_W-1:0] ty_abs;

    // step arithmetic
    logic signed [DEC_W-1:0]   rx2_d;
    logic signed [DEC_W-1:0]   ry2_d;
    logic signed [DEC_W-1:0]   prod_d;
    logic signed [SLOPE_W-1:0] two_rx2;
    logic signed [SLOPE_W-1:0] two_ry2;
    logic signed [SLOPE_W-1:0] sdx_inc;
    logic signed [SLOPE_W-1:0] sdy_dec;
    logic signed [DEC_W-1:0]   sdx_inc_d;
    logic signed [DEC_W-1:0]   sdy_dec_d;
    logic signed [DEC_W-1:0]   term;
    logic        [OFF_W-1:0]   off_x_next;
    logic        [OFF_W-1:0]   off_y_next;
    logic signed [SLOPE_W-1:0] sdx_next;
    logic signed [SLOPE_W-1:0] sdy_next;
    logic signed [DEC_W-1:0]   dec_next;
    logic                      last_now;

    // point sums
    logic [SUM_W-1:0] mx;
    logic [SUM_W-1:0] my;
    logic [SUM_W-1:0] ox;
    logic [SUM_W-1:0] oy;
    logic [SUM_W-1:0] x_plus;
    logic [SUM_W-1:0] x_minus;
    logic [SUM_W-1:0] y_plus;
    logic [SUM_W-1:0] y_minus;

    assign status.active      = active_reg;
    assign status.need_switch = !region2_reg && (sdx_reg >= sdy_reg);
    assign status.out_free    = !out_valid_reg || !out_stall;

    assign tx     = {off_x_reg, 1'b1};
    assign ty_abs = (off_y_reg == '0) ? OFF_W'(1) : off_y_reg - OFF_W'(1);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (op)
            OP_SQ_RX:
            begin
                mul_a = SQ_W'(rad_x_reg);
                mul_b = MB_W'(rad_x_reg);
            end
            OP_SQ_RY:
            begin
                mul_a = SQ_W'(off_y_reg);
                mul_b = MB_W'(off_y_reg);
            end
            OP_RX2_RY:
            begin
                mul_a = rx2_reg;
                mul_b = MB_W'(off_y_reg);
            end
            OP_TX_SQ:
            begin
                mul_a = SQ_W'(tx);
                mul_b = MB_W'(tx);
            end
            OP_RY2_TX:
            begin
                mul_a = ry2_reg;
                mul_b = prod_reg[MB_W-1:0];
            end
            OP_TY_SQ:
            begin
                mul_a = SQ_W'(ty_abs);
                mul_b = MB_W'(ty_abs);
            end
            OP_RX2_TY:
            begin
                mul_a = rx2_reg;
                mul_b = prod_reg[MB_W-1:0];
            end
            OP_RX2_RY2:
            begin
                mul_a = rx2_reg;
                mul_b = MB_W'(ry2_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = {{MB_W{1'b0}}, mul_a} * {{SQ_W{1'b0}}, mul_b};

    assign rx2_d     = DEC_W'(rx2_reg);
    assign ry2_d     = DEC_W'(ry2_reg);
    assign prod_d    = prod_reg;
    assign two_rx2   = SLOPE_W'({rx2_reg, 1'b0});
    assign two_ry2   = SLOPE_W'({ry2_reg, 1'b0});
    assign sdx_inc   = sdx_reg + two_ry2;
    assign sdy_dec   = sdy_reg - two_rx2;
    assign sdx_inc_d = DEC_W'(sdx_inc);
    assign sdy_dec_d = DEC_W'(sdy_dec);
    assign last_now  = region2_reg && (off_y_reg == '0);

    always_comb
    begin
        off_x_next = off_x_reg;
        off_y_next = off_y_reg;
        sdx_next   = sdx_reg;
        sdy_next   = sdy_reg;
        term       = '0;
        if (!region2_reg)
        begin
            off_x_next = off_x_reg + OFF_W'(1);
            sdx_next   = sdx_inc;
            if (dec_reg[DEC_W-1])
            begin
                term = sdx_inc_d + ry2_d;
            end
            else
            begin
                off_y_next = off_y_reg - OFF_W'(1);
                sdy_next   = sdy_dec;
                term       = sdx_inc_d - sdy_dec_d + ry2_d;
            end
        end
        else
        begin
            off_y_next = off_y_reg - OFF_W'(1);
            sdy_next   = sdy_dec;
            if (!dec_reg[DEC_W-1] && (dec_reg != '0))
            begin
                term = rx2_d - sdy_dec_d;
            end
            else
            begin
                off_x_next = off_x_reg + OFF_W'(1);
                sdx_next   = sdx_inc;
                term       = sdx_inc_d - sdy_dec_d + rx2_d;
            end
        end
        dec_next = dec_reg + (term <<< 2);
    end

    assign mx      = SUM_W'(mid_x_reg);
    assign my      = SUM_W'(mid_y_reg);
    assign ox      = SUM_W'(off_x_reg);
    assign oy      = SUM_W'(off_y_reg);
    assign x_plus  = mx + ox;
    assign x_minus = mx - ox;
    assign y_plus  = my + oy;
    assign y_minus = my - oy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            region2_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (op == OP_LOAD)
            begin
                active_reg  <= 1'b1;
                region2_reg <= 1'b0;
            end
            if (op == OP_SWITCH)
            begin
                region2_reg <= 1'b1;
            end
            if (op == OP_EMIT)
            begin
                out_valid_reg <= 1'b1;
                if (last_now)
                begin
                    active_reg <= 1'b0;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (op)
            OP_LOAD:
            begin
                mid_x_reg <= center_x;
                mid_y_reg <= center_y;
                rad_x_reg <= axis_x;
                off_x_reg <= '0;
                off_y_reg <= OFF_W'(axis_y);
                sdx_reg   <= '0;
            end
            OP_SQ_RX:
            begin
                prod_reg <= mul_p;
            end
            OP_SQ_RY:
            begin
                rx2_reg  <= prod_reg[SQ_W-1:0];
                prod_reg <= mul_p;
            end
            OP_RX2_RY:
            begin
                ry2_reg  <= prod_reg[SQ_W-1:0];
                prod_reg <= mul_p;
            end
            OP_INIT:
            begin
                sdy_reg <= SLOPE_W'({prod_reg, 1'b0});
                dec_reg <= (ry2_d <<< 2) - (prod_d <<< 2) + rx2_d;
            end
            OP_TX_SQ, OP_RY2_TX, OP_RX2_TY:
            begin
                prod_reg <= mul_p;
            end
            OP_TY_SQ:
            begin
                acc_reg  <= prod_d;
                prod_reg <= mul_p;
            end
            OP_RX2_RY2:
            begin
                acc_reg  <= acc_reg + (prod_d <<< 2);
                prod_reg <= mul_p;
            end
            OP_SWITCH:
            begin
                dec_reg <= acc_reg - (prod_d <<< 2);
            end
            OP_EMIT:
            begin
                pt0_x_reg <= x_plus[PT_W-1:0];
                pt0_y_reg <= y_plus[PT_W-1:0];
                pt1_x_reg <= x_minus[PT_W-1:0];
                pt1_y_reg <= y_plus[PT_W-1:0];
                pt2_x_reg <= x_plus[PT_W-1:0];
                pt2_y_reg <= y_minus[PT_W-1:0];
                pt3_x_reg <= x_minus[PT_W-1:0];
                pt3_y_reg <= y_minus[PT_W-1:0];
                last_reg  <= last_now;
                if (!last_now)
                begin
                    off_x_reg <= off_x_next;
                    off_y_reg <= off_y_next;
                    sdx_reg   <= sdx_next;
                    sdy_reg   <= sdy_next;
                    dec_reg   <= dec_next;
                end
            end
            default:
            begin
                // hold
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign pt0_x     = pt0_x_reg;
    assign pt0_y     = pt0_y_reg;
    assign pt1_x     = pt1_x_reg;
    assign pt1_y     = pt1_y_reg;
    assign pt2_x     = pt2_x_reg;
    assign pt2_y     = pt2_y_reg;
    assign pt3_x     = pt3_x_reg;
    assign pt3_y     = pt3_y_reg;
    assign last      = last_reg;

endmodule

/* rtl/core/midpoint_ellipse_rasterizer.sv */
// Start word: accepted, then setup on the shared multiplier (squares, rx^2*ry, decision setup);
// no result. Advance word: accepted in idle; the emit state registers the point set when the
// output register is free. Input stalls until the sequencer is back in idle, one word at a time.
// The advance that enters region two first runs the multiplier chain and the region switch.
// Async active-low reset clears the sequencer, active/region flags and out_valid;
// the block then ignores advance words until a start word arrives.
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer
    import mer_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int RADIUS_BITS = RADIUS_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          action,
    input  logic [COORD_BITS-1:0]         center_x,
    input  logic [COORD_BITS-1:0]         center_y,
    input  logic [RADIUS_BITS-1:0]        axis_x,
    input  logic [RADIUS_BITS-1:0]        axis_y,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [COORD_BITS+1:0]  pt0_x,
    output logic signed [COORD_BITS+1:0]  pt0_y,
    output logic signed [COORD_BITS+1:0]  pt1_x,
    output logic signed [COORD_BITS+1:0]  pt1_y,
    output logic signed [COORD_BITS+1:0]  pt2_x,
    output logic signed [COORD_BITS+1:0]  pt2_y,
    output logic signed [COORD_BITS+1:0]  pt3_x,
    output logic signed [COORD_BITS+1:0]  pt3_y,
    output logic                          last
);

    dp_op_t     op;
    dp_status_t status;

    mer_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .in_stall (in_stall),
        .op       (op),
        .status   (status)
    );

    mer_dp #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .status    (status),
        .center_x  (center_x),
        .center_y  (center_y),
        .axis_x    (axis_x),
        .axis_y    (axis_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pt0_x     (pt0_x),
        .pt0_y     (pt0_y),
        .pt1_x     (pt1_x),
        .pt1_y     (pt1_y),
        .pt2_x     (pt2_x),
        .pt2_y     (pt2_y),
        .pt3_x     (pt3_x),
        .pt3_y     (pt3_y),
        .last      (last)
    );

endmodule

/* rtl/core/mer_checker.sv */
// Port-level checks for the midpoint ellipse rasterizer, bound to the top level.
// Depends on mer_pkg and midpoint_ellipse_rasterizer_assert.svh.
`timescale 1ns / 1ps
`include "midpoint_ellipse_rasterizer_assert.svh"

module mer_checker
    import mer_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          action,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic signed [COORD_BITS+1:0]  pt0_x,
    input logic                          last
);

    // setup runs its multiplier steps and the decision setup before the next word may enter
    `MER_ASSERT_NEXT(a_start_busy, in_valid && !in_stall && action == ACT_START, in_stall ##1 in_stall ##1 in_stall ##1 in_stall, "start word did not hold off input during setup")

    // a new output word is loaded only from the emit step, which blocks input
    `MER_ASSERT_SAME(a_out_from_emit, $rose(out_valid), $past(in_stall), "output word appeared without an emit step")

    `MER_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(pt0_x) && $stable(last), "stalled output word changed")

endmodule

bind midpoint_ellipse_rasterizer mer_checker #(.COORD_BITS(COORD_BITS)) u_mer_checker (.*);
